@@ rtl/wmx_pkg.sv @@
// Shared types and constants for the two-channel white mixing PWM block.
`default_nettype none

package wmx_pkg;

   // Request action codes
   localparam logic [1:0] ACT_POWER = 2'd0;
   localparam logic [1:0] ACT_LEVEL = 2'd1;
   localparam logic [1:0] ACT_TEMP  = 2'd2;

   // Register indexes and reset values
   localparam int         CSR_IDX_W  = 1;
   localparam int         CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WARM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COOL = 1'b1;
   localparam logic [15:0] WARM_RESET  = 16'd500;
   localparam logic [15:0] COOL_RESET  = 16'd153;
   localparam logic [7:0]  LEVEL_RESET = 8'd1;

   // Job queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Divide by five: floor(x * DIV5_MUL / 2^DIV5_SHIFT), exact for x < 2^17
   localparam int             DIV5_W     = 19;
   localparam logic [18:0]    DIV5_MUL   = 19'd419431;
   localparam int             DIV5_SHIFT = 21;

   typedef struct packed {
      logic [1:0]  action;
      logic        power_on;
      logic [7:0]  level;
      logic [15:0] mireds;
   } req_type;

   typedef struct packed {
      logic [12:0] warm_duty;
      logic [12:0] cold_duty;
      logic [9:0]  fade_time;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  level;
      logic [15:0] mireds;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SETUP,
      BK_MUL,
      BK_DIV,
      BK_DIFF,
      BK_FADE
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/wmx_front.sv @@
// Front end: accepts requests, keeps level/temperature/power state, queues mix jobs.
`default_nettype none

module wmx_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wmx_pkg::req_type        req,
   input  wmx_pkg::queue_stat_type q_stat,
   output logic                    push,
   output wmx_pkg::job_type        push_job
);
   import wmx_pkg::*;

   logic [7:0]  held_level_ff,  held_level_in;
   logic [15:0] held_mireds_ff, held_mireds_in;
   logic        lamp_on_ff,     lamp_on_in;
   logic        emit;
   logic        accept;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && emit;

   // Classify the request and work out the next held state
   always_comb begin
      held_level_in   = held_level_ff;
      held_mireds_in  = held_mireds_ff;
      lamp_on_in      = lamp_on_ff;
      emit            = 1'b0;
      push_job.level  = held_level_ff;
      push_job.mireds = held_mireds_ff;
      unique case (req.action)
         ACT_POWER: begin
            if (!req.power_on) begin
               held_level_in  = 8'd0;
               push_job.level = 8'd0;
               emit           = lamp_on_ff;
            end
            lamp_on_in = req.power_on;
         end
         ACT_LEVEL: begin
            held_level_in  = req.level;
            push_job.level = req.level;
            emit           = lamp_on_ff;
         end
         ACT_TEMP: begin
            held_mireds_in  = req.mireds;
            push_job.mireds = req.mireds;
            emit            = lamp_on_ff;
         end
         default: begin
         end
      endcase
   end

   // Update held state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         held_level_ff  <= LEVEL_RESET;
         held_mireds_ff <= 16'd0;
         lamp_on_ff     <= 1'b1;
      end else if (accept) begin
         held_level_ff  <= held_level_in;
         held_mireds_ff <= held_mireds_in;
         lamp_on_ff     <= lamp_on_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/wmx_queue.sv @@
// Short job queue between the front end and the mixing back end.
`default_nettype none

module wmx_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wmx_pkg::job_type        push_job,
   input  wire                     pop,
   output wmx_pkg::job_type        pop_job,
   output wmx_pkg::queue_stat_type stat
);
   import wmx_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_job    = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/wmx_back.sv @@
// Back end: computes warm/cold duties with serial dividers, fade time and result register.
`default_nettype none

module wmx_back #(
   parameter int DUTY_BITS  = 12,
   parameter int FULL_LEVEL = 254
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [15:0]             warm_limit,
   input  wire  [15:0]             cool_limit,
   input  wmx_pkg::queue_stat_type q_stat,
   output logic                    pop,
   input  wmx_pkg::job_type        job,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output wmx_pkg::rsp_type        rsp
);
   import wmx_pkg::*;

   localparam int DW   = DUTY_BITS + 1;     // duty 0..2^DUTY_BITS
   localparam int PW   = 25;                // 2 * weight(16) * level(8)
   localparam int NW   = PW + DUTY_BITS;    // dividend width
   localparam int DENW = 24;                // span(16) * full level(8)
   localparam int RW   = DENW + 1;
   localparam int CW   = $clog2(NW + 1);
   localparam int MW   = DW + DIV5_W;

   localparam logic [DW-1:0] DUTY_FULL = DW'(1) << DUTY_BITS;

   back_state_type  state_ff, state_in;
   logic [7:0]      lvl_ff;
   logic [15:0]     temp_ff;
   logic [15:0]     aw_ff, ac_ff, span_ff;
   logic [DENW-1:0] den_ff;
   logic [NW-1:0]   numw_ff, numc_ff;
   logic [DENW-1:0] remw_ff, remc_ff;
   logic [CW-1:0]   cnt_ff;
   logic [DW-1:0]   lastw_ff, lastc_ff;
   logic [DW-1:0]   dutyw_ff, dutyc_ff;
   logic [DW-1:0]   diffw_ff, diffc_ff;
   rsp_type         rsp_ff;
   logic            rsp_valid_ff;

   logic            out_free;
   logic [15:0]     t_clamp;
   logic [PW-2:0]   aw_lvl, ac_lvl;
   logic [DENW-1:0] den_prod;
   logic [RW-1:0]   rw_try, rc_try;
   logic            gew, gec;
   logic [DW-1:0]   dutyw, dutyc;
   logic [DW-1:0]   max_diff;
   logic [MW-1:0]   fade_prod;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Sequence one job: setup, multiply, divide, compare, deliver
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               state_in = BK_SETUP;
            end
         end
         BK_SETUP: state_in = BK_MUL;
         BK_MUL:   state_in = BK_DIV;
         BK_DIV: begin
            if (cnt_ff == CW'(1)) begin
               state_in = BK_DIFF;
            end
         end
         BK_DIFF:  state_in = BK_FADE;
         BK_FADE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Clamp temperature into the span
   always_comb begin
      if (temp_ff < cool_limit) begin
         t_clamp = cool_limit;
      end else if (temp_ff > warm_limit) begin
         t_clamp = warm_limit;
      end else begin
         t_clamp = temp_ff;
      end
   end

   // Products for dividends and divisor
   assign aw_lvl   = aw_ff * lvl_ff;
   assign ac_lvl   = ac_ff * lvl_ff;
   assign den_prod = span_ff * DENW'(FULL_LEVEL);

   // One restoring division step per channel
   assign rw_try = {remw_ff, numw_ff[NW-1]};
   assign rc_try = {remc_ff, numc_ff[NW-1]};
   assign gew    = (rw_try >= {1'b0, den_ff});
   assign gec    = (rc_try >= {1'b0, den_ff});

   // Saturate quotients
   assign dutyw = (numw_ff > NW'(DUTY_FULL)) ? DUTY_FULL : numw_ff[DW-1:0];
   assign dutyc = (numc_ff > NW'(DUTY_FULL)) ? DUTY_FULL : numc_ff[DW-1:0];

   // Fade is the larger change divided by five
   assign max_diff  = (diffw_ff > diffc_ff) ? diffw_ff : diffc_ff;
   assign fade_prod = MW'(max_diff) * MW'(DIV5_MUL);

   // Datapath registers
   always_ff @(posedge clock) begin
      if (pop) begin
         lvl_ff  <= job.level;
         temp_ff <= job.mireds;
      end
      if (state_ff == BK_SETUP) begin
         if (warm_limit > cool_limit) begin
            aw_ff   <= t_clamp - cool_limit;
            ac_ff   <= warm_limit - t_clamp;
            span_ff <= warm_limit - cool_limit;
         end else begin
            aw_ff   <= 16'd1;
            ac_ff   <= 16'd1;
            span_ff <= 16'd2;
         end
      end
      if (state_ff == BK_MUL) begin
         numw_ff <= NW'({aw_lvl, 1'b0}) << DUTY_BITS;
         numc_ff <= NW'({ac_lvl, 1'b0}) << DUTY_BITS;
         den_ff  <= den_prod;
         remw_ff <= '0;
         remc_ff <= '0;
         cnt_ff  <= CW'(NW);
      end
      if (state_ff == BK_DIV) begin
         remw_ff <= gew ? DENW'(rw_try - {1'b0, den_ff}) : rw_try[DENW-1:0];
         remc_ff <= gec ? DENW'(rc_try - {1'b0, den_ff}) : rc_try[DENW-1:0];
         numw_ff <= {numw_ff[NW-2:0], gew};
         numc_ff <= {numc_ff[NW-2:0], gec};
         cnt_ff  <= cnt_ff - 1'b1;
      end
      if (state_ff == BK_DIFF) begin
         dutyw_ff <= dutyw;
         dutyc_ff <= dutyc;
         diffw_ff <= (lastw_ff > dutyw) ? lastw_ff - dutyw : dutyw - lastw_ff;
         diffc_ff <= (lastc_ff > dutyc) ? lastc_ff - dutyc : dutyc - lastc_ff;
      end
      if (state_ff == BK_FADE && out_free) begin
         rsp_ff.warm_duty <= 13'(dutyw_ff);
         rsp_ff.cold_duty <= 13'(dutyc_ff);
         rsp_ff.fade_time <= 10'(fade_prod >> DIV5_SHIFT);
      end
   end

   // Last duties and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         lastw_ff     <= '0;
         lastc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == BK_DIFF) begin
            lastw_ff <= dutyw;
            lastc_ff <= dutyc;
         end
         if (state_ff == BK_FADE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/two_channel_white_mix_pwm.sv @@
// Top level of the two-channel tunable-white mixer with PWM duty outputs.
//
// Requests (req_*) carry power, brightness or color-temperature updates.
// The front end applies each one to the held level, temperature and power
// flag in the cycle it is taken; when the lamp is on, a brightness or
// temperature update, or a power-off, queues one mix job. Power-on and
// updates while off give no response.
// Responses (rsp_*) carry warm and cold duty counts and a fade time.
// A job passes through the back end's setup, multiply, divide, compare
// and fade steps; the divide step runs two restoring dividers in parallel,
// one quotient bit per cycle over DUTY_BITS + 25 bits, and the fade step
// loads the output register and raises rsp_valid. One job is in the back end
// at a time; up to two more wait in the queue, and requests that cause no
// response keep flowing while it holds space. When the receiver stalls, the
// finished response is held in the output register and the back end waits
// only at its last step.
// csr_* writes the warm and cool span limits; write them only while idle.
// Reset restores the limits to 500 and 153 mireds, the level to 1, the
// temperature to 0, the lamp to on, the last duties to zero, and empties
// the queue and output register.
`default_nettype none

module two_channel_white_mix_pwm #(
   parameter int DUTY_BITS  = 12,
   parameter int FULL_LEVEL = 254
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wmx_pkg::req_type                 req,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output wmx_pkg::rsp_type                 rsp,
   input  wire                              csr_we,
   input  wire  [wmx_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [wmx_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import wmx_pkg::*;

   logic [15:0]    warm_limit_ff;
   logic [15:0]    cool_limit_ff;
   queue_stat_type q_stat;
   logic           q_push;
   logic           q_pop;
   job_type        q_push_job;
   job_type        q_pop_job;

   // Span limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         warm_limit_ff <= WARM_RESET;
         cool_limit_ff <= COOL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WARM: warm_limit_ff <= csr_wdata;
            CSR_COOL: cool_limit_ff <= csr_wdata;
         endcase
      end
   end

   wmx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_job  (q_push_job)
   );

   wmx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .stat     (q_stat)
   );

   wmx_back #(
      .DUTY_BITS  (DUTY_BITS),
      .FULL_LEVEL (FULL_LEVEL)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .warm_limit (warm_limit_ff),
      .cool_limit (cool_limit_ff),
      .q_stat     (q_stat),
      .pop        (q_pop),
      .job        (q_pop_job),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // Never push a job into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job pushed into full queue");

   // Never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("job popped from empty queue");

   // Full and empty are exclusive
   a_stat_exclusive: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_stat.empty)
      else $error("queue reports full and empty together");

endmodule

`default_nettype wire

@@ dv/tb_two_channel_white_mix_pwm.sv @@
// Self-checking testbench for the two-channel tunable-white mixing PWM block.
`default_nettype none

module tb_two_channel_white_mix_pwm;
   timeunit 1ns;
   timeprecision 1ps;

   import wmx_pkg::*;

   localparam int          DUTY_BITS     = 12;
   localparam int          FULL_LEVEL    = 254;
   localparam logic [63:0] FULL_SCALE    = 64'd1 << DUTY_BITS;
   localparam int          SETTLE_CYCLES = DUTY_BITS + 48;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam logic [1:0]  ACT_UNUSED    = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow of the block's registers and held state
   logic [15:0] span_warm;
   logic [15:0] span_cool;
   logic [7:0]  held_level;
   logic [15:0] held_mireds;
   logic        lamp_on;
   logic [12:0] last_duty [2];

   rsp_type expected_mixes [$];
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      fail_count    = 0;
   int      cycle_count   = 0;

   two_channel_white_mix_pwm #(
      .DUTY_BITS (DUTY_BITS),
      .FULL_LEVEL(FULL_LEVEL)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp_payload),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("two_channel_white_mix_pwm test failed");
         $finish;
      end
   end

   // Duty of one channel, truncated and saturated at full scale
   function automatic logic [12:0] saturate_duty(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      q = num / den;
      return (q > FULL_SCALE) ? FULL_SCALE[12:0] : q[12:0];
   endfunction

   // Store level and temperature; while on, queue the expected duties and fade
   function automatic void mix_duties(logic [7:0] lvl, logic [15:0] temp);
      logic [63:0] t;
      logic [63:0] warm;
      logic [63:0] cool;
      logic [63:0] den;
      logic [63:0] diff;
      logic [63:0] fade;
      logic [12:0] duty [2];
      rsp_type     mix;
      held_level  = lvl;
      held_mireds = temp;
      if (!lamp_on) return;
      warm = 64'(span_warm);
      cool = 64'(span_cool);
      if (warm <= cool) begin
         duty[0] = saturate_duty(64'(lvl) * FULL_SCALE, 64'(FULL_LEVEL));
         duty[1] = duty[0];
      end else begin
         t = 64'(temp);
         if (t < cool) t = cool;
         if (t > warm) t = warm;
         den = (warm - cool) * 64'(FULL_LEVEL);
         duty[0] = saturate_duty(64'd2 * (t - cool) * 64'(lvl) * FULL_SCALE, den);
         duty[1] = saturate_duty(64'd2 * (warm - t) * 64'(lvl) * FULL_SCALE, den);
      end
      fade = 64'd0;
      for (int ch = 0; ch < 2; ch++) begin
         diff = (last_duty[ch] > duty[ch]) ? 64'(last_duty[ch] - duty[ch])
                                           : 64'(duty[ch] - last_duty[ch]);
         if (diff / 64'd5 > fade) fade = diff / 64'd5;
         last_duty[ch] = duty[ch];
      end
      mix.warm_duty = duty[0];
      mix.cold_duty = duty[1];
      mix.fade_time = fade[9:0];
      expected_mixes.push_back(mix);
   endfunction

   // Apply one accepted request to the shadow state
   function automatic void predict_request(req_type r);
      case (r.action)
         ACT_POWER: begin
            if (!r.power_on) mix_duties(8'd0, held_mireds);
            lamp_on = r.power_on;
         end
         ACT_LEVEL: mix_duties(r.level, held_mireds);
         ACT_TEMP:  mix_duties(held_level, r.mireds);
         default: ;
      endcase
   endfunction

   // Check each response against the oldest expectation; drive ready
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mixes.size() == 0) begin
            $error("response with no request pending: warm %0d cold %0d fade %0d",
                   rsp_payload.warm_duty, rsp_payload.cold_duty, rsp_payload.fade_time);
            fail_count++;
         end else begin
            want = expected_mixes.pop_front();
            if (rsp_payload.warm_duty !== want.warm_duty) begin
               $error("warm_duty: expected %0d, actual %0d",
                      want.warm_duty, rsp_payload.warm_duty);
               fail_count++;
            end
            if (rsp_payload.cold_duty !== want.cold_duty) begin
               $error("cold_duty: expected %0d, actual %0d",
                      want.cold_duty, rsp_payload.cold_duty);
               fail_count++;
            end
            if (rsp_payload.fade_time !== want.fade_time) begin
               $error("fade_time: expected %0d, actual %0d",
                      want.fade_time, rsp_payload.fade_time);
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Present one request, hold it until taken, then idle at random
   task automatic send_request(req_type r);
      req_payload <= r;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Stop sending and wait for every outstanding response plus settle time
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_mixes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both span limits on consecutive cycles while the block is idle
   task automatic write_span(logic [15:0] warm, logic [15:0] cool);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_WARM;
      csr_wdata <= warm;
      @(posedge clock);
      csr_index <= CSR_COOL;
      csr_wdata <= cool;
      @(posedge clock);
      csr_we    <= 1'b0;
      span_warm = warm;
      span_cool = cool;
   endtask

   function automatic req_type make_request(logic [1:0] action, logic pwr,
                                            logic [7:0] lvl, logic [15:0] mir);
      req_type r;
      r.action   = action;
      r.power_on = pwr;
      r.level    = lvl;
      r.mireds   = mir;
      return r;
   endfunction

   // Random request, mostly level and temperature updates; power requests mostly turn the lamp on
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned lo;
      int unsigned hi;
      r.power_on = 1'($urandom_range(1));
      r.level    = 8'($urandom_range(255));
      r.mireds   = 16'($urandom_range(65535));
      pick       = $urandom_range(99);
      if (pick < 40) begin
         r.action = ACT_LEVEL;
      end else if (pick < 80) begin
         r.action = ACT_TEMP;
         if ($urandom_range(3) != 0) begin
            lo = (span_warm < span_cool) ? 32'(span_warm) : 32'(span_cool);
            hi = (span_warm < span_cool) ? 32'(span_cool) : 32'(span_warm);
            r.mireds = 16'(lo + $urandom_range(hi - lo));
         end
      end else if (pick < 92) begin
         r.action   = ACT_POWER;
         r.power_on = ($urandom_range(9) < 7);
      end else begin
         r.action = ACT_UNUSED;
      end
      return r;
   endfunction

   // Level and temperature extremes, clamping, saturation, unused action
   task automatic test_mix_basics();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_request(make_request(ACT_TEMP,   1'b0, 8'd0,   16'd153));
      send_request(make_request(ACT_LEVEL,  1'b1, 8'd254, 16'd0));
      send_request(make_request(ACT_TEMP,   1'b1, 8'd0,   16'd500));
      send_request(make_request(ACT_TEMP,   1'b0, 8'd255, 16'd0));
      send_request(make_request(ACT_TEMP,   1'b1, 8'd0,   16'hFFFF));
      send_request(make_request(ACT_TEMP,   1'b0, 8'd0,   16'd326));
      send_request(make_request(ACT_LEVEL,  1'b0, 8'd255, 16'hFFFF));
      send_request(make_request(ACT_LEVEL,  1'b1, 8'd0,   16'd0));
      send_request(make_request(ACT_UNUSED, 1'b0, 8'd200, 16'd400));
   endtask

   // Power off while on and off, updates while off, power back on
   task automatic test_power_control();
      send_idle_pct = 15;
      rsp_stall_pct = 15;
      send_request(make_request(ACT_LEVEL, 1'b0, 8'd180, 16'd0));
      send_request(make_request(ACT_POWER, 1'b1, 8'd0,   16'd0));
      send_request(make_request(ACT_POWER, 1'b0, 8'hFF,  16'hFFFF));
      send_request(make_request(ACT_POWER, 1'b0, 8'd0,   16'd0));
      send_request(make_request(ACT_LEVEL, 1'b0, 8'd200, 16'd0));
      send_request(make_request(ACT_TEMP,  1'b0, 8'd0,   16'd400));
      send_request(make_request(ACT_POWER, 1'b1, 8'd0,   16'd0));
      send_request(make_request(ACT_LEVEL, 1'b1, 8'd128, 16'd0));
      send_request(make_request(ACT_POWER, 1'b0, 8'd0,   16'd0));
      send_request(make_request(ACT_POWER, 1'b1, 8'd0,   16'd0));
   endtask

   // Empty, inverted and widest spans
   task automatic test_span_edges();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_span(16'd300, 16'd300);
      send_request(make_request(ACT_LEVEL, 1'b0, 8'd254, 16'd0));
      send_request(make_request(ACT_LEVEL, 1'b1, 8'd255, 16'd0));
      write_span(16'd100, 16'd400);
      send_request(make_request(ACT_TEMP,  1'b0, 8'd0,   16'd250));
      write_span(16'hFFFF, 16'd0);
      send_request(make_request(ACT_TEMP,  1'b1, 8'd0,   16'h8000));
      send_request(make_request(ACT_TEMP,  1'b0, 8'd0,   16'hFFFF));
   endtask

   // Random traffic under one span setting and one idling mix
   task automatic test_random_traffic(logic [15:0] warm, logic [15:0] cool,
                                      int send_pct, int stall_pct, int count,
                                      bit pause_midway);
      req_type r;
      int      sent;
      bit      paused;
      sent   = 0;
      paused = 1'b0;
      write_span(warm, cool);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      while (sent < count) begin
         r = random_request();
         send_request(r);
         if (r.action != ACT_UNUSED) sent++;
         // Hold off until the block has fully drained once
         if (pause_midway && !paused && sent >= count / 2) begin
            paused = 1'b1;
            wait_idle();
         end
      end
   endtask

   initial begin
      logic [15:0] rand_warm;
      logic [15:0] rand_cool;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_we      <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      span_warm    = WARM_RESET;
      span_cool    = COOL_RESET;
      held_level   = LEVEL_RESET;
      held_mireds  = 16'd0;
      lamp_on      = 1'b1;
      last_duty[0] = '0;
      last_duty[1] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_mix_basics();
      test_power_control();
      test_span_edges();

      rand_warm = 16'($urandom_range(65535));
      rand_cool = 16'($urandom_range(65535));
      test_random_traffic(WARM_RESET, COOL_RESET, 0,  0,  125, 1'b1);
      test_random_traffic(16'hFFFF,   16'd0,      63, 0,  125, 1'b0);
      test_random_traffic(16'd0,      16'hFFFF,   0,  63, 125, 1'b0);
      test_random_traffic(rand_warm,  rand_cool,  15, 15, 125, 1'b1);
      test_random_traffic(16'd40010,  16'd40000,  63, 0,  125, 1'b0);
      test_random_traffic(16'hFFFF,   16'hFFFF,   0,  63, 125, 1'b0);

      wait_idle();
      if (fail_count == 0) begin
         $display("two_channel_white_mix_pwm test passed");
      end else begin
         $display("two_channel_white_mix_pwm test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/wmx_pkg.sv
rtl/wmx_front.sv
rtl/wmx_queue.sv
rtl/wmx_back.sv
rtl/two_channel_white_mix_pwm.sv
dv/tb_two_channel_white_mix_pwm.sv
